// File: rtl/jspm_pkg.sv
`default_nettype none

package jspm_pkg;

    localparam int AXIS_BITS = 16;
    localparam int PWM_BITS  = 12;

    // config register widths
    localparam int DB_BITS    = AXIS_BITS - 1;
    localparam int DGAIN_BITS = 16;
    localparam int CFG_PWM_W  = 12;
    localparam int TICK_BITS  = 16;

    // apb port
    localparam int CFG_AW = 5;
    localparam int CFG_DW = 32;

    // rescale arithmetic
    localparam int DGAIN_FRAC = 14;
    localparam int MUL_A_BITS = AXIS_BITS;
    localparam int MUL_B_BITS = (DGAIN_BITS > CFG_PWM_W) ? DGAIN_BITS : CFG_PWM_W;
    localparam int MUL_BITS   = MUL_A_BITS + MUL_B_BITS;
    localparam int RS_BITS    = MUL_BITS - DGAIN_FRAC;
    localparam int OFF_BITS   = CFG_PWM_W + 1;
    localparam int SUM_BITS   = CFG_PWM_W + 3;
    localparam logic [AXIS_BITS-1:0] AXIS_FS = AXIS_BITS'(1) << (AXIS_BITS - 1);

    localparam int PWM_MIN = 700;
    localparam int PWM_MAX = 2300;

    // register reset values
    localparam logic [DB_BITS-1:0]    RST_DEADBAND      = DB_BITS'(3932);
    localparam logic [DGAIN_BITS-1:0] RST_DEADBAND_GAIN = DGAIN_BITS'(18618);
    localparam logic [CFG_PWM_W-1:0]  RST_PWM_GAIN      = CFG_PWM_W'(500);
    localparam logic [CFG_PWM_W-1:0]  RST_PWM_IDLE      = CFG_PWM_W'(1500);
    localparam logic [CFG_PWM_W-1:0]  RST_NEUTRAL_PWM   = CFG_PWM_W'(1500);
    localparam logic [CFG_PWM_W-1:0]  RST_ROTATE_PWM    = CFG_PWM_W'(1765);
    localparam logic [TICK_BITS-1:0]  RST_ROTATE_TICKS  = TICK_BITS'(50);

    // queue between front and back
    localparam int QUEUE_AW    = 1;
    localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

    typedef enum logic [2:0] {
        REG_DEADBAND      = 3'd0,
        REG_DEADBAND_GAIN = 3'd1,
        REG_PWM_GAIN      = 3'd2,
        REG_PWM_IDLE      = 3'd3,
        REG_NEUTRAL_PWM   = 3'd4,
        REG_ROTATE_PWM    = 3'd5,
        REG_ROTATE_TICKS  = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic [DB_BITS-1:0]    deadband;
        logic [DGAIN_BITS-1:0] deadband_gain;
        logic [CFG_PWM_W-1:0]  span_us;
        logic [CFG_PWM_W-1:0]  mid_us;
        logic [CFG_PWM_W-1:0]  rest_us;
        logic [CFG_PWM_W-1:0]  turn_us;
        logic [TICK_BITS-1:0]  rotate_ticks;
    } t_cfg;

    // one classified tick as it travels through the queue
    typedef struct packed {
        logic [AXIS_BITS-1:0] diff_sh;
        logic                 neg_sh;
        logic [AXIS_BITS-1:0] diff_wr;
        logic                 neg_wr;
        logic                 wrist_ovr;
        logic [CFG_PWM_W-1:0] wrist_ovr_val;
        logic                 start_cmd;
        logic                 stop_cmd;
        logic                 rotating;
    } t_item;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_OFF_SH,
        BK_MUL_WR,
        BK_OFF_WR,
        BK_DONE
    } t_back_state;

    // magnitude above the deadband, zero inside it
    function automatic logic [AXIS_BITS-1:0] deadband_diff(
        input logic signed [AXIS_BITS-1:0] axis,
        input logic [DB_BITS-1:0]          db
    );
        logic [AXIS_BITS-1:0] mag;
        logic [AXIS_BITS-1:0] db_ext;
        mag    = axis[AXIS_BITS-1] ? AXIS_BITS'(-axis) : AXIS_BITS'(axis);
        db_ext = {1'b0, db};
        return (mag >= db_ext) ? (mag - db_ext) : '0;
    endfunction

    // rescaled magnitude, saturated to full scale
    function automatic logic [AXIS_BITS-1:0] rescale_sat(input logic [MUL_BITS-1:0] prod);
        logic [RS_BITS-1:0] r;
        r = prod[MUL_BITS-1:DGAIN_FRAC];
        return (r > RS_BITS'(AXIS_FS)) ? AXIS_FS : r[AXIS_BITS-1:0];
    endfunction

    // idle plus signed offset, clamped to the servo range
    function automatic logic [PWM_BITS-1:0] pwm_clamp(
        input logic [MUL_BITS-1:0]  prod,
        input logic                 neg,
        input logic [CFG_PWM_W-1:0] idle
    );
        logic [OFF_BITS-1:0]        off;
        logic signed [SUM_BITS-1:0] v;
        off = prod[AXIS_BITS-1+OFF_BITS-1:AXIS_BITS-1];
        v   = $signed({3'b000, idle});
        if (neg) begin
            v = v - $signed({2'b00, off});
        end else begin
            v = v + $signed({2'b00, off});
        end
        if (v < SUM_BITS'(PWM_MIN)) begin
            return PWM_BITS'(PWM_MIN);
        end else if (v > SUM_BITS'(PWM_MAX)) begin
            return PWM_BITS'(PWM_MAX);
        end
        return v[PWM_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

// File: rtl/jspm_front.sv
`default_nettype none

module jspm_front
    import jspm_pkg::*;
(
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire t_cfg                        i_cfg,
    input  wire logic                        i_valid,
    input  wire logic signed [AXIS_BITS-1:0] i_sh_axis,
    input  wire logic signed [AXIS_BITS-1:0] i_wr_axis,
    input  wire logic                        i_y_btn,
    input  wire logic                        i_start_btn,
    input  wire logic                        i_stop_btn,
    input  wire logic                        i_full,
    output logic                             o_push,
    output t_item                            o_item
);

    logic                 r_prev_y, r_prev_start, r_prev_stop, r_rot_active;
    logic [TICK_BITS-1:0] r_ticks_left;
    logic                 n_rot_active;
    logic [TICK_BITS-1:0] n_ticks_left;

    assign o_push = i_valid && !i_full;

    always_comb begin
        n_rot_active = r_rot_active;
        n_ticks_left = r_ticks_left;
        o_item       = '0;

        if (i_y_btn && !r_prev_y && !r_rot_active) begin
            n_rot_active = 1'b1;
            n_ticks_left = i_cfg.rotate_ticks;
        end
        if (n_rot_active) begin
            o_item.wrist_ovr = 1'b1;
            if (n_ticks_left != '0) begin
                o_item.wrist_ovr_val = i_cfg.turn_us;
                n_ticks_left         = n_ticks_left - TICK_BITS'(1);
            end else begin
                o_item.wrist_ovr_val = i_cfg.rest_us;
                n_rot_active         = 1'b0;
            end
        end

        o_item.diff_sh   = deadband_diff(i_sh_axis, i_cfg.deadband);
        o_item.neg_sh    = i_sh_axis[AXIS_BITS-1];
        o_item.diff_wr   = deadband_diff(i_wr_axis, i_cfg.deadband);
        o_item.neg_wr    = i_wr_axis[AXIS_BITS-1];
        o_item.start_cmd = i_start_btn && !r_prev_start;
        o_item.stop_cmd  = i_stop_btn && !r_prev_stop;
        o_item.rotating  = n_rot_active;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_y     <= 1'b0;
            r_prev_start <= 1'b0;
            r_prev_stop  <= 1'b0;
            r_rot_active <= 1'b0;
            r_ticks_left <= '0;
        end else if (o_push) begin
            r_prev_y     <= i_y_btn;
            r_prev_start <= i_start_btn;
            r_prev_stop  <= i_stop_btn;
            r_rot_active <= n_rot_active;
            r_ticks_left <= n_ticks_left;
        end
    end

endmodule

`default_nettype wire

// File: rtl/jspm_queue.sv
`default_nettype none

module jspm_queue
    import jspm_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_item i_item,
    input  wire logic  i_pop,
    output t_item      o_head,
    output logic       o_full,
    output logic       o_empty
);

    t_item               r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wptr, r_rptr;
    logic [QUEUE_AW:0]   r_count;

    assign o_head  = r_mem[r_rptr];
    assign o_full  = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + QUEUE_AW'(1);
            end
            if (i_pop) begin
                r_rptr <= r_rptr + QUEUE_AW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (QUEUE_AW+1)'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - (QUEUE_AW+1)'(1);
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/jspm_back.sv
`default_nettype none

module jspm_back
    import jspm_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cfg        i_cfg,
    input  wire t_item       i_head,
    input  wire logic        i_empty,
    output logic             o_pop,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [PWM_BITS-1:0] o_shoulder_pwm,
    output logic [PWM_BITS-1:0] o_wrist_pwm,
    output logic [PWM_BITS-1:0] o_aux_pwm,
    output logic             o_start_cmd,
    output logic             o_stop_cmd,
    output logic             o_rotating
);

    t_back_state           r_state, n_state;
    t_item                 r_item;
    logic [MUL_BITS-1:0]   r_prod;
    logic [PWM_BITS-1:0]   r_sh_pwm;
    logic                  r_out_valid;
    logic                  out_free, out_load, mul_en;
    logic [MUL_A_BITS-1:0] mul_a;
    logic [MUL_B_BITS-1:0] mul_b;

    assign out_free = !r_out_valid || !i_out_stall;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE:   if (!i_empty) n_state = BK_OFF_SH;
            BK_OFF_SH: n_state = BK_MUL_WR;
            BK_MUL_WR: n_state = BK_OFF_WR;
            BK_OFF_WR: n_state = BK_DONE;
            BK_DONE: begin
                if (out_free) begin
                    n_state = i_empty ? BK_IDLE : BK_OFF_SH;
                end
            end
            default:   n_state = BK_IDLE;
        endcase
    end

    // sequencer outputs: pop, output load and shared multiplier operands
    always_comb begin
        o_pop    = 1'b0;
        out_load = 1'b0;
        mul_en   = 1'b0;
        mul_a    = rescale_sat(r_prod);
        mul_b    = MUL_B_BITS'(i_cfg.span_us);
        case (r_state)
            BK_IDLE: begin
                o_pop  = !i_empty;
                mul_en = !i_empty;
                mul_a  = i_head.diff_sh;
                mul_b  = MUL_B_BITS'(i_cfg.deadband_gain);
            end
            BK_OFF_SH: begin
                mul_en = 1'b1;
            end
            BK_MUL_WR: begin
                mul_en = 1'b1;
                mul_a  = r_item.diff_wr;
                mul_b  = MUL_B_BITS'(i_cfg.deadband_gain);
            end
            BK_OFF_WR: begin
                mul_en = 1'b1;
            end
            BK_DONE: begin
                out_load = out_free;
                o_pop    = out_free && !i_empty;
                mul_en   = out_free && !i_empty;
                mul_a    = i_head.diff_sh;
                mul_b    = MUL_B_BITS'(i_cfg.deadband_gain);
            end
            default: begin
                mul_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= i_head;
        end
        if (mul_en) begin
            r_prod <= mul_a * mul_b;
        end
        if (r_state == BK_MUL_WR) begin
            r_sh_pwm <= pwm_clamp(r_prod, r_item.neg_sh, i_cfg.mid_us);
        end
        if (out_load) begin
            o_shoulder_pwm <= r_sh_pwm;
            o_wrist_pwm    <= r_item.wrist_ovr ? PWM_BITS'(r_item.wrist_ovr_val)
                                               : pwm_clamp(r_prod, r_item.neg_wr,
                                                           i_cfg.mid_us);
            o_aux_pwm      <= PWM_BITS'(i_cfg.rest_us);
            o_start_cmd    <= r_item.start_cmd;
            o_stop_cmd     <= r_item.stop_cmd;
            o_rotating     <= r_item.rotating;
        end
    end

    assign o_out_valid = r_out_valid;

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> !i_empty)
        else $error("pop from empty queue");

    a_seq_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_OFF_SH) |-> $past(o_pop))
        else $error("sequence started without a pop");

    a_load_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> (r_state == BK_DONE) && out_free)
        else $error("output loaded outside done state");

    a_sh_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (o_shoulder_pwm >= PWM_BITS'(PWM_MIN))
                     && (o_shoulder_pwm <= PWM_BITS'(PWM_MAX)))
        else $error("shoulder pwm out of clamp range");

endmodule

`default_nettype wire

// File: rtl/joystick_servo_pwm_mapper_core.sv
`default_nettype none

// joystick to servo pwm mapper: one transaction on the input channel is one control tick
// (two q1.15 axes, three button levels) and yields exactly one output transaction with three
// pulse widths, the start/stop command pulses and the rotation flag. the front stage takes a
// tick, tracks button edges and the timed wrist override, and removes the deadband; a
// two-entry queue feeds the back stage, where a single 16x16 multiplier makes four products
// per tick (rescale and pwm gain for each axis) followed by clamping to 700..2300. the shared
// multiplier holds the back stage to one tick at a time: once busy, it pops the next tick only
// as it loads the output register, after the states off_sh, mul_wr, off_wr and done. the input
// stalls only while the queue is full. registers sit on an apb port at byte address 4*index
// and read back; write them only while no tick is in flight. no clearing pass after reset.

module joystick_servo_pwm_mapper_core
    import jspm_pkg::*;
(
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // config port
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [CFG_AW-1:0]           paddr,
    input  wire logic [CFG_DW-1:0]           pwdata,
    output logic [CFG_DW-1:0]                prdata,
    output logic                             pready,
    // tick input
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic signed [AXIS_BITS-1:0] i_sh_axis,
    input  wire logic signed [AXIS_BITS-1:0] i_wr_axis,
    input  wire logic                        i_y_btn,
    input  wire logic                        i_start_btn,
    input  wire logic                        i_stop_btn,
    // result output
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic [PWM_BITS-1:0]              o_shoulder_pwm,
    output logic [PWM_BITS-1:0]              o_wrist_pwm,
    output logic [PWM_BITS-1:0]              o_aux_pwm,
    output logic                             o_start_cmd,
    output logic                             o_stop_cmd,
    output logic                             o_rotating
);

    t_cfg     r_cfg;
    t_reg_idx reg_idx;
    logic     cfg_wr;
    t_item    push_item, head_item;
    logic     push, pop, q_full, q_empty;

    // register file
    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[CFG_AW-1:2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.deadband      <= RST_DEADBAND;
            r_cfg.deadband_gain <= RST_DEADBAND_GAIN;
            r_cfg.span_us       <= RST_PWM_GAIN;
            r_cfg.mid_us        <= RST_PWM_IDLE;
            r_cfg.rest_us       <= RST_NEUTRAL_PWM;
            r_cfg.turn_us       <= RST_ROTATE_PWM;
            r_cfg.rotate_ticks  <= RST_ROTATE_TICKS;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_DEADBAND:      r_cfg.deadband      <= pwdata[DB_BITS-1:0];
                REG_DEADBAND_GAIN: r_cfg.deadband_gain <= pwdata[DGAIN_BITS-1:0];
                REG_PWM_GAIN:      r_cfg.span_us       <= pwdata[CFG_PWM_W-1:0];
                REG_PWM_IDLE:      r_cfg.mid_us        <= pwdata[CFG_PWM_W-1:0];
                REG_NEUTRAL_PWM:   r_cfg.rest_us       <= pwdata[CFG_PWM_W-1:0];
                REG_ROTATE_PWM:    r_cfg.turn_us       <= pwdata[CFG_PWM_W-1:0];
                REG_ROTATE_TICKS:  r_cfg.rotate_ticks  <= pwdata[TICK_BITS-1:0];
                default:           r_cfg               <= r_cfg;
            endcase
        end
    end

    // read back, unused addresses read zero
    always_comb begin
        case (reg_idx)
            REG_DEADBAND:      prdata = CFG_DW'(r_cfg.deadband);
            REG_DEADBAND_GAIN: prdata = CFG_DW'(r_cfg.deadband_gain);
            REG_PWM_GAIN:      prdata = CFG_DW'(r_cfg.span_us);
            REG_PWM_IDLE:      prdata = CFG_DW'(r_cfg.mid_us);
            REG_NEUTRAL_PWM:   prdata = CFG_DW'(r_cfg.rest_us);
            REG_ROTATE_PWM:    prdata = CFG_DW'(r_cfg.turn_us);
            REG_ROTATE_TICKS:  prdata = CFG_DW'(r_cfg.rotate_ticks);
            default:           prdata = '0;
        endcase
    end

    // input stalls only on a full queue
    assign o_in_stall = q_full;

    jspm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_valid     (i_in_valid),
        .i_sh_axis   (i_sh_axis),
        .i_wr_axis   (i_wr_axis),
        .i_y_btn     (i_y_btn),
        .i_start_btn (i_start_btn),
        .i_stop_btn  (i_stop_btn),
        .i_full      (q_full),
        .o_push      (push),
        .o_item      (push_item)
    );

    jspm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_head  (head_item),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // shared multiplier sequencer and output register
    jspm_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_head         (head_item),
        .i_empty        (q_empty),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_shoulder_pwm (o_shoulder_pwm),
        .o_wrist_pwm    (o_wrist_pwm),
        .o_aux_pwm      (o_aux_pwm),
        .o_start_cmd    (o_start_cmd),
        .o_stop_cmd     (o_stop_cmd),
        .o_rotating     (o_rotating)
    );

endmodule

`default_nettype wire
